// ----- hw/rtl/aiot_pkg.sv -----
package aiot_pkg;

    localparam int TableDepth = 32;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);
    localparam int PosW = 36;
    localparam int IdW = 32;
    localparam int CoordW = 32;
    localparam int DirW = 16;
    localparam int RegIdxW = 2;
    localparam int QDepth = 2;

    localparam logic [RegIdxW-1:0] REG_DIR_X = 2'd0;
    localparam logic [RegIdxW-1:0] REG_DIR_Y = 2'd1;
    localparam logic [RegIdxW-1:0] REG_DIR_Z = 2'd2;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_ERASE = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_DUP = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [IdW-1:0] entity_id;
        logic signed [CoordW-1:0] near_x;
        logic signed [CoordW-1:0] near_y;
        logic signed [CoordW-1:0] near_z;
        logic signed [CoordW-1:0] far_x;
        logic signed [CoordW-1:0] far_y;
        logic signed [CoordW-1:0] far_z;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic hit_valid;
        logic [IdW-1:0] hit_entity;
        logic last;
    } t_out_word;

    // Classified command passed from the projection front to the table engine.
    typedef struct packed {
        logic [1:0] mode;
        logic [IdW-1:0] entity_id;
        logic signed [PosW-1:0] near_pos;
        logic signed [PosW-1:0] far_pos;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_EMIT
    } t_eng_state;

    typedef enum logic [2:0] {
        F_IDLE,
        F_NEAR,
        F_FAR,
        F_SUM,
        F_PUSH
    } t_front_state;

endpackage

// ----- hw/rtl/aiot_front.sv -----
module aiot_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  aiot_pkg::t_in_word                  i_word,
    input  logic signed [aiot_pkg::DirW-1:0]    i_dir_x,
    input  logic signed [aiot_pkg::DirW-1:0]    i_dir_y,
    input  logic signed [aiot_pkg::DirW-1:0]    i_dir_z,
    output logic                                o_cmd_valid,
    input  logic                                i_cmd_ready,
    output aiot_pkg::t_cmd                      o_cmd
);
    import aiot_pkg::*;

    localparam int ProdW = CoordW + DirW;
    localparam int SumW = ProdW + 2;

    t_front_state r_state, n_state;
    t_in_word r_word;
    logic signed [ProdW-1:0] r_px, r_py, r_pz;
    logic signed [PosW-1:0] r_near, r_far;
    logic signed [SumW-1:0] w_sum;
    logic w_sel_far;

    // Products are registered before the sum; near and far share the multipliers.
    assign w_sel_far = (r_state == F_FAR);
    assign w_sum = SumW'(r_px) + SumW'(r_py) + SumW'(r_pz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (i_push) n_state = F_NEAR;
            F_NEAR: n_state = F_FAR;
            F_FAR: n_state = F_SUM;
            F_SUM: n_state = F_PUSH;
            F_PUSH: if (i_cmd_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_push) begin
            r_word <= i_word;
        end
        if (r_state == F_NEAR || r_state == F_FAR) begin
            r_px <= i_dir_x * (w_sel_far ? r_word.far_x : r_word.near_x);
            r_py <= i_dir_y * (w_sel_far ? r_word.far_y : r_word.near_y);
            r_pz <= i_dir_z * (w_sel_far ? r_word.far_z : r_word.near_z);
        end
        // Arithmetic shift floors toward minus infinity.
        if (r_state == F_FAR) begin
            r_near <= PosW'(w_sum >>> 14);
        end
        if (r_state == F_SUM) begin
            r_far <= PosW'(w_sum >>> 14);
        end
    end

    assign o_full = (r_state != F_IDLE);
    assign o_cmd_valid = (r_state == F_PUSH);
    assign o_cmd.mode = r_word.mode;
    assign o_cmd.entity_id = r_word.entity_id;
    assign o_cmd.near_pos = r_near;
    assign o_cmd.far_pos = r_far;

endmodule

// ----- hw/rtl/aiot_cmd_queue.sv -----
module aiot_cmd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  aiot_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output aiot_pkg::t_cmd  o_cmd
);
    import aiot_pkg::*;

    localparam int PtrW = $clog2(QDepth);

    t_cmd r_mem [QDepth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [PtrW:0] r_cnt;
    logic w_wr, w_rd;

    assign o_ready = (r_cnt != (PtrW+1)'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign w_wr = i_valid && o_ready;
    assign w_rd = o_valid && i_ready;
    assign o_cmd = r_mem[r_rd];

    // Two-entry command queue between the front and the engine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wr <= r_wr + 1'b1;
            if (w_rd) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(w_wr) - (PtrW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr] <= i_cmd;
    end

endmodule

// ----- hw/rtl/aiot_engine.sv -----
module aiot_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  aiot_pkg::t_cmd       i_cmd,
    output logic                 o_empty,
    input  logic                 i_pop,
    output aiot_pkg::t_out_word  o_word
);
    import aiot_pkg::*;

    t_eng_state r_state, n_state;
    t_cmd r_cmd;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_idx;
    logic [CntW-1:0] r_found;
    logic r_hit_any;
    logic r_out_valid, n_out_valid;
    t_out_word r_out, n_out;

    logic signed [PosW-1:0] r_start [TableDepth];
    logic signed [PosW-1:0] r_end [TableDepth];
    logic [IdW-1:0] r_owner [TableDepth];

    logic [IdxW-1:0] w_i;
    logic w_in_range, w_match, w_overlap, w_out_free, w_tbl_full;
    logic [IdxW-1:0] w_ip1;

    assign w_i = r_idx[IdxW-1:0];
    assign w_ip1 = IdxW'(r_idx + 1'b1);
    assign w_in_range = (r_idx < r_count);
    assign w_match = (r_owner[w_i] == r_cmd.entity_id);
    assign w_overlap = (r_end[w_i] >= r_cmd.near_pos) && (r_start[w_i] <= r_cmd.far_pos);
    assign w_out_free = !r_out_valid || i_pop;
    assign w_tbl_full = (r_count == CntW'(TableDepth));
    assign o_empty = !r_out_valid;
    assign o_word = r_out;
    assign o_cmd_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_cmd_valid) n_state = S_SCAN;
            S_SCAN: begin
                if (!w_in_range) begin
                    n_state = S_EMIT;
                end else if (r_cmd.mode == MODE_QUERY) begin
                    n_state = S_SCAN;
                end else if (w_match) begin
                    n_state = (r_cmd.mode == MODE_ERASE) ? S_SHIFT : S_EMIT;
                end
            end
            S_SHIFT: if (r_idx + 1'b1 >= r_count) n_state = S_EMIT;
            S_EMIT: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Output register: a query hit is sent once the next hit is found,
    // and the closing word carries last.
    always_comb begin
        n_out_valid = r_out_valid && !i_pop;
        n_out = r_out;
        case (r_state)
            S_SCAN: begin
                if (w_in_range && r_cmd.mode == MODE_QUERY && w_overlap && r_hit_any &&
                    w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{ST_DONE, 1'b1, r_owner[r_found[IdxW-1:0]], 1'b0};
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{ST_DONE, 1'b0, '0, 1'b1};
                    case (r_cmd.mode)
                        MODE_INSERT: begin
                            if (r_hit_any) n_out.status = ST_DUP;
                            else if (w_tbl_full) n_out.status = ST_FULL;
                        end
                        MODE_ERASE: begin
                            if (!r_hit_any) n_out.status = ST_ABSENT;
                        end
                        MODE_QUERY: begin
                            if (r_hit_any) begin
                                n_out.hit_valid = 1'b1;
                                n_out.hit_entity = r_owner[r_found[IdxW-1:0]];
                            end
                        end
                        default: n_out.status = ST_DONE;
                    endcase
                end
            end
            default: n_out = r_out;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Scan, compaction and update, one entry per cycle unless stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    r_found <= '0;
                    r_hit_any <= 1'b0;
                    if (i_cmd_valid) r_cmd <= i_cmd;
                end
                S_SCAN: begin
                    if (w_in_range) begin
                        if (r_cmd.mode == MODE_QUERY) begin
                            if (!w_overlap) begin
                                r_idx <= r_idx + 1'b1;
                            end else if (!r_hit_any || w_out_free) begin
                                r_found <= r_idx;
                                r_hit_any <= 1'b1;
                                r_idx <= r_idx + 1'b1;
                            end
                        end else if (w_match) begin
                            r_hit_any <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_SHIFT: begin
                    if (r_idx + 1'b1 < r_count) begin
                        r_start[w_i] <= r_start[w_ip1];
                        r_end[w_i] <= r_end[w_ip1];
                        r_owner[w_i] <= r_owner[w_ip1];
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        case (r_cmd.mode)
                            MODE_INSERT: begin
                                if (!r_hit_any && !w_tbl_full) begin
                                    r_start[r_count[IdxW-1:0]] <= r_cmd.near_pos;
                                    r_end[r_count[IdxW-1:0]] <= r_cmd.far_pos;
                                    r_owner[r_count[IdxW-1:0]] <= r_cmd.entity_id;
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            MODE_ERASE: begin
                                if (r_hit_any) r_count <= r_count - 1'b1;
                            end
                            default: r_count <= r_count;
                        endcase
                    end
                end
                default: r_idx <= '0;
            endcase
        end
    end

endmodule

// ----- hw/rtl/axis_interval_overlap_table_core.sv -----
// One-axis interval overlap table (sweep-and-prune broadphase).
// Input channel: a word is taken when push is high and full is low.
// Each word is projected onto the axis (dir_x, dir_y, dir_z): two fixed-point
// dot products, floored to a 36-bit near and far position.
// Insert appends an entry, erase removes one and compacts the table, and
// query returns every overlapping entry id in table order with last set.
// Result channel: the oldest result sits on o_word while empty is low and
// is taken when pop is high.
// The front projects each word through its near, far, sum and push states and
// hands it to the command queue; the engine then scans the table one entry per
// cycle unless a query hit waits on the output, and an erase trades scanned
// entries for shifted ones.
// Query hits are held one behind so the final one can carry last; each hit
// waits in the output register, and a stalled receiver stops the scan.
// The front projects the next word while the engine works (two-word queue).
// Reset empties the table and sets the axis to x.
// Configuration writes take effect at once and must be made while idle.
module axis_interval_overlap_table_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  aiot_pkg::t_in_word                   i_word,
    output logic                                 empty,
    input  logic                                 pop,
    output aiot_pkg::t_out_word                  o_word,
    input  logic                                 i_cfg_we,
    input  logic [aiot_pkg::RegIdxW-1:0]         i_cfg_idx,
    input  logic [aiot_pkg::DirW-1:0]            i_cfg_data
);
    import aiot_pkg::*;

    logic signed [DirW-1:0] r_dir_x, r_dir_y, r_dir_z;
    logic w_fc_valid, w_fc_ready, w_qe_valid, w_qe_ready;
    t_cmd w_fc_cmd, w_qe_cmd;

    // Axis registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_x <= 16'sd16384;
            r_dir_y <= '0;
            r_dir_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DIR_X: r_dir_x <= i_cfg_data;
                REG_DIR_Y: r_dir_y <= i_cfg_data;
                REG_DIR_Z: r_dir_z <= i_cfg_data;
                default: r_dir_x <= r_dir_x;
            endcase
        end
    end

    aiot_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_word(i_word), .i_dir_x(r_dir_x), .i_dir_y(r_dir_y), .i_dir_z(r_dir_z),
        .o_cmd_valid(w_fc_valid), .i_cmd_ready(w_fc_ready), .o_cmd(w_fc_cmd)
    );

    aiot_cmd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_fc_valid), .o_ready(w_fc_ready),
        .i_cmd(w_fc_cmd), .o_valid(w_qe_valid), .i_ready(w_qe_ready), .o_cmd(w_qe_cmd)
    );

    aiot_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_qe_valid),
        .o_cmd_ready(w_qe_ready), .i_cmd(w_qe_cmd), .o_empty(empty), .i_pop(pop),
        .o_word(o_word)
    );

endmodule

// ----- hw/rtl/aiot_checker.sv -----
module aiot_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic                 empty,
    input  logic                 pop,
    input  aiot_pkg::t_out_word  o_word
);
    import aiot_pkg::*;

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_word))
        else $error("result changed while stalled");

    // A miss always closes its item.
    a_miss_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_word.hit_valid |-> o_word.last)
        else $error("no-hit result without last");

    // Hits carry done status.
    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_word.hit_valid |-> o_word.status == ST_DONE)
        else $error("hit with error status");

    // The input is blocked right after a word is taken.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> full)
        else $error("front accepted without projecting");

endmodule

bind axis_interval_overlap_table_core aiot_checker u_aiot_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
    .empty(empty), .pop(pop), .o_word(o_word)
);

// ----- dv/axis_interval_overlap_table_core_test.sv -----
module axis_interval_overlap_table_core_test;
    import aiot_pkg::*;

    localparam int StallLimit = 20000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [RegIdxW-1:0] REG_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    t_in_word i_word = '0;
    logic empty;
    logic pop = 1'b0;
    t_out_word o_word;
    logic i_cfg_we = 1'b0;
    logic [RegIdxW-1:0] i_cfg_idx = '0;
    logic [DirW-1:0] i_cfg_data = '0;

    axis_interval_overlap_table_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_word(i_word),
        .empty(empty), .pop(pop), .o_word(o_word), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: axis and table contents.
    logic signed [DirW-1:0] axis_x, axis_y, axis_z;
    logic signed [PosW-1:0] tbl_start [TableDepth];
    logic signed [PosW-1:0] tbl_end [TableDepth];
    logic [IdW-1:0] tbl_id [TableDepth];
    int tbl_count;

    t_out_word expected_words [$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    bit hold_go = 1'b0;
    bit hold_used = 1'b0;
    int quiet_cycles = 0;
    bit run_over = 1'b0;

    // Floor of the dot product shifted by 14 (arithmetic shift floors).
    function automatic logic signed [PosW-1:0] axis_position(
        logic signed [CoordW-1:0] cx, logic signed [CoordW-1:0] cy,
        logic signed [CoordW-1:0] cz);
        logic signed [63:0] acc;
        acc = 64'(axis_x) * 64'(cx) + 64'(axis_y) * 64'(cy) + 64'(axis_z) * 64'(cz);
        return PosW'(acc >>> 14);
    endfunction

    function automatic int find_entity(logic [IdW-1:0] id);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_id[i] == id) return i;
        return -1;
    endfunction

    function automatic t_out_word status_word(logic [1:0] st);
        t_out_word w;
        w = '0;
        w.status = st;
        w.last = 1'b1;
        return w;
    endfunction

    // Append one word to the expected results.
    task automatic expect_word(t_out_word w);
        expected_words = {expected_words, w};
    endtask

    // Apply one accepted word to the table and queue its expected results.
    task automatic predict_table(t_in_word w);
        logic signed [PosW-1:0] near_p, far_p;
        t_out_word r;
        int at;
        int hits;
        near_p = axis_position(w.near_x, w.near_y, w.near_z);
        far_p = axis_position(w.far_x, w.far_y, w.far_z);
        hits = 0;
        case (w.mode)
            MODE_INSERT: begin
                if (find_entity(w.entity_id) >= 0) begin
                    expect_word(status_word(ST_DUP));
                end else if (tbl_count >= TableDepth) begin
                    expect_word(status_word(ST_FULL));
                end else begin
                    tbl_start[tbl_count] = near_p;
                    tbl_end[tbl_count] = far_p;
                    tbl_id[tbl_count] = w.entity_id;
                    tbl_count++;
                    expect_word(status_word(ST_DONE));
                end
            end
            MODE_ERASE: begin
                at = find_entity(w.entity_id);
                if (at < 0) begin
                    expect_word(status_word(ST_ABSENT));
                end else begin
                    for (int i = at; i + 1 < tbl_count; i++) begin
                        tbl_start[i] = tbl_start[i+1];
                        tbl_end[i] = tbl_end[i+1];
                        tbl_id[i] = tbl_id[i+1];
                    end
                    tbl_count--;
                    expect_word(status_word(ST_DONE));
                end
            end
            MODE_QUERY: begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_end[i] >= near_p && tbl_start[i] <= far_p) begin
                        r = '0;
                        r.hit_valid = 1'b1;
                        r.hit_entity = tbl_id[i];
                        expect_word(r);
                        hits++;
                    end
                end
                if (hits == 0) expect_word(status_word(ST_DONE));
                else expected_words[$].last = 1'b1;
            end
            default: expect_word(status_word(ST_DONE));
        endcase
    endtask

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Drive one word and wait for it to be taken; push stays high afterward
    // so that back-to-back words need no gap.
    task automatic send_word(t_in_word w);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        i_word <= w;
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_table(w);
    endtask

    task automatic write_axis(logic [RegIdxW-1:0] idx, logic [DirW-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_DIR_X) axis_x = v;
        else if (idx == REG_DIR_Y) axis_y = v;
        else if (idx == REG_DIR_Z) axis_z = v;
        @(posedge i_clk);
    endtask

    // Wait until every result has arrived, then let the engine settle.
    task automatic drain_results();
        push <= 1'b0;
        while (expected_words.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_in_word make_word(logic [1:0] m, logic [IdW-1:0] id,
        logic signed [CoordW-1:0] nx, logic signed [CoordW-1:0] fx);
        t_in_word w;
        w = '0;
        w.mode = m;
        w.entity_id = id;
        w.near_x = nx;
        w.far_x = fx;
        return w;
    endfunction

    function automatic logic signed [CoordW-1:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return CoordW'($signed($urandom_range(2000)) - 1000) <<< 16;
            default: return CoordW'($signed($urandom_range(200)) - 100) <<< 16;
        endcase
    endfunction

    function automatic logic [DirW-1:0] rand_axis();
        case ($urandom_range(3))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return DirW'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    // Receiver: random pop with one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_go && !hold_used) begin
            hold_used <= 1'b1;
            hold_cycles <= 600;
            pop <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end else begin
            pop <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", o_word));
            end else begin
                if (o_word.status != expected_words[0].status)
                    report_mismatch($sformatf("status %0d, want %0d",
                        o_word.status, expected_words[0].status));
                if (o_word.hit_valid != expected_words[0].hit_valid)
                    report_mismatch($sformatf("hit_valid %0b, want %0b",
                        o_word.hit_valid, expected_words[0].hit_valid));
                if (o_word.hit_entity != expected_words[0].hit_entity)
                    report_mismatch($sformatf("hit_entity %h, want %h",
                        o_word.hit_entity, expected_words[0].hit_entity));
                if (o_word.last != expected_words[0].last)
                    report_mismatch($sformatf("last %0b, want %0b",
                        o_word.last, expected_words[0].last));
                void'(expected_words.pop_front());
            end
        end
    end

    // Watchdog on cycles with no handshake.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (!run_over && quiet_cycles >= StallLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    typedef struct {
        t_in_word w;
        bit typed;
        logic [1:0] st;
    } t_directed_row;

    t_directed_row directed_rows [$];

    initial begin
        t_in_word w;
        t_directed_row row;
        logic [IdW-1:0] known_ids [$];
        int n_rand;
        int phase;
        axis_x = 16'sd16384;
        axis_y = '0;
        axis_z = '0;
        tbl_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: status-only rows carry their expected code.
        directed_rows = '{
            '{make_word(MODE_QUERY, 0, 0, 0), 1, ST_DONE},
            '{make_word(MODE_ERASE, 32'hFFFF_FFFF, 0, 0), 1, ST_ABSENT},
            '{make_word(MODE_INSERT, 32'hFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF), 1, ST_DONE},
            '{make_word(MODE_INSERT, 32'hFFFF_FFFF, 0, 0), 1, ST_DUP},
            '{make_word(MODE_INSERT, 0, 32'sh0001_0000, 32'sh0002_0000), 1, ST_DONE},
            '{make_word(MODE_INSERT, 7, 32'sh0005_0000, 32'sh0003_0000), 1, ST_DONE},
            '{make_word(MODE_QUERY, 0, 32'sh0002_0000, 32'sh0002_0000), 0, ST_DONE},
            '{make_word(MODE_QUERY, 0, 32'sh7FFF_FFFF, 32'sh8000_0000), 0, ST_DONE},
            '{make_word(MODE_QUERY, 0, 32'sh8000_0000, 32'sh7FFF_FFFF), 0, ST_DONE},
            '{make_word(MODE_UNUSED, 5, 0, 0), 1, ST_DONE},
            '{make_word(MODE_ERASE, 0, 0, 0), 1, ST_DONE},
            '{make_word(MODE_QUERY, 0, 32'sh0003_0000, 32'sh0003_0000), 0, ST_DONE}
        };
        for (int i = 0; i < 34; i++) begin
            row = '{make_word(MODE_INSERT, IdW'(100 + i), CoordW'(i <<< 16),
                CoordW'((i + 1) <<< 16)), i < 30, i < 30 ? ST_DONE : ST_FULL};
            directed_rows = {directed_rows, row};
        end
        row = '{make_word(MODE_QUERY, 0, 32'sh8000_0000, 32'sh7FFF_FFFF), 0, ST_DONE};
        directed_rows = {directed_rows, row};
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_word(row.w);
            if (row.typed && (expected_words[$].status != row.st || !expected_words[$].last))
                report_mismatch($sformatf("row %0d predicted status %0d, table says %0d",
                    i, expected_words[$].status, row.st));
        end
        drain_results();
        // Empty the table again so the random part starts small.
        for (int i = 0; i < 32; i++)
            send_word(make_word(MODE_ERASE, IdW'(100 + 31 - i), 0, 0));
        send_word(make_word(MODE_ERASE, 32'hFFFF_FFFF, 0, 0));
        send_word(make_word(MODE_ERASE, 7, 0, 0));
        drain_results();

        // Random part in three idling phases, with new axis settings each phase.
        n_rand = 0;
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 23 : (phase == 1 ? 76 : 0);
            recv_idle_pct = phase == 0 ? 76 : (phase == 1 ? 23 : 0);
            drain_results();
            write_axis(REG_DIR_X, phase == 2 ? rand_axis() : (phase == 0 ? 16'h8000 : 16'h4000));
            write_axis(REG_DIR_Y, phase == 1 ? 16'hC000 : rand_axis());
            write_axis(REG_DIR_Z, rand_axis());
            write_axis(REG_UNUSED, 16'hFFFF);
            if (phase == 2) hold_go = 1'b1;
            for (int k = 0; k < 93; k++) begin
                w = '0;
                w.near_x = rand_coord();
                w.near_y = rand_coord();
                w.near_z = rand_coord();
                w.far_x = w.near_x + ($urandom_range(40) <<< 16);
                w.far_y = rand_coord();
                w.far_z = rand_coord();
                if ($urandom_range(9) == 0) w.far_x = $urandom;
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        w.mode = MODE_INSERT;
                        w.entity_id = ($urandom_range(4) == 0 && known_ids.size() > 0)
                            ? known_ids[$urandom_range(known_ids.size() - 1)] : $urandom;
                        known_ids = {known_ids, w.entity_id};
                    end
                    4, 5: begin
                        w.mode = MODE_ERASE;
                        w.entity_id = ($urandom_range(3) != 0 && known_ids.size() > 0)
                            ? known_ids[$urandom_range(known_ids.size() - 1)] : $urandom;
                    end
                    9: begin
                        w.mode = MODE_UNUSED;
                        w.entity_id = $urandom;
                    end
                    default: begin
                        w.mode = MODE_QUERY;
                        w.entity_id = $urandom;
                    end
                endcase
                send_word(w);
                n_rand++;
            end
        end

        // Final settle with extremes on the axis checked by a last query set.
        drain_results();
        write_axis(REG_DIR_X, 16'h8000);
        write_axis(REG_DIR_Y, 16'h8000);
        write_axis(REG_DIR_Z, 16'h8000);
        send_word(make_word(MODE_QUERY, 0, 32'sh8000_0000, 32'sh7FFF_FFFF));
        drain_results();
        run_over = 1'b1;
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/aiot_pkg.sv
hw/rtl/aiot_front.sv
hw/rtl/aiot_cmd_queue.sv
hw/rtl/aiot_engine.sv
hw/rtl/axis_interval_overlap_table_core.sv
hw/rtl/aiot_checker.sv
dv/axis_interval_overlap_table_core_test.sv
